// ===== sv/bps_pkg.sv =====
// ----------------------------------------------------------------------------
// Byte pattern search package
// Shared constants, register codes and beat types of the pattern search core.
// ----------------------------------------------------------------------------
package bps_pkg;

  // Longest pattern the window can hold.
  localparam int unsigned MaxPattern = 8;

  localparam int unsigned PatW     = 64;
  localparam int unsigned LenW     = 4;
  localparam int unsigned AddrW    = 32;
  localparam int unsigned CountW   = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  localparam logic [CountW-1:0] LimitReset = 16'd16;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPattern = 3'd0,
    CfgLength  = 3'd1,
    CfgStart   = 3'd2,
    CfgEnd     = 3'd3,
    CfgLimit   = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       scan_start;
  } in_beat_t;

  typedef struct packed {
    logic [AddrW-1:0]  match_address;
    logic [CountW-1:0] match_number;
    logic              limit_reached;
  } out_beat_t;

  // Control handed from the top level to every window cell.
  typedef struct packed {
    logic shift;
    logic clear;
    logic active;
  } cell_ctrl_t;

  function automatic logic [7:0] pattern_byte(logic [PatW-1:0] pat, logic [2:0] idx);
    return pat[idx*8 +: 8];
  endfunction

endpackage

// ===== sv/byte_pattern_search_core.sv =====
// ----------------------------------------------------------------------------
// Byte pattern search core
// Sliding-window search of a byte stream for a pattern of up to eight bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Memory bytes enter on the in channel, one beat per byte in ascending
//   address order; scan_start on a beat begins a new scan at start_address,
//   clearing the window, the address and the match count. Each beat that
//   completes a match of the last pattern_length bytes yields one beat on the
//   out channel with the address of the match's first byte, its ordinal and
//   a flag when the ordinal equals match_limit. Bytes at or past end_address
//   are dropped, and no further match is reported once the limit is met.
//   The window is a row of seven byte cells that shift once per accepted
//   beat below end_address and compare in parallel. A match appears on the
//   out channel in the cycle after its byte is taken. The core takes one
//   byte every cycle unless a stalled result waits in the output register
//   and is not taken, in which case in_ready_o drops until it is. Reset
//   restores the register defaults, empties the window and clears the
//   output. Write registers only while idle; the core does not enforce it.
// ----------------------------------------------------------------------------
module byte_pattern_search_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bps_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [bps_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  bps_pkg::in_beat_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output bps_pkg::out_beat_t             out_data_o
);

  localparam int unsigned LenW   = bps_pkg::LenW;
  localparam int unsigned AddrW  = bps_pkg::AddrW;
  localparam int unsigned CountW = bps_pkg::CountW;
  localparam int unsigned MaxPat = bps_pkg::MaxPattern;

  // Configuration registers
  logic [bps_pkg::PatW-1:0] pattern_q;
  logic [LenW-1:0]          length_q;
  logic [AddrW-1:0]         start_q, end_q;
  logic [CountW-1:0]        limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      length_q  <= LenW'(1);
      start_q   <= '0;
      end_q     <= '0;
      limit_q   <= bps_pkg::LimitReset;
    end else if (cfg_we_i) begin
      case (bps_pkg::cfg_reg_e'(cfg_index_i))
        bps_pkg::CfgPattern: pattern_q <= cfg_wdata_i[bps_pkg::PatW-1:0];
        bps_pkg::CfgLength:  length_q  <= cfg_wdata_i[LenW-1:0];
        bps_pkg::CfgStart:   start_q   <= cfg_wdata_i[AddrW-1:0];
        bps_pkg::CfgEnd:     end_q     <= cfg_wdata_i[AddrW-1:0];
        bps_pkg::CfgLimit:   limit_q   <= cfg_wdata_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // Scan state
  logic [AddrW-1:0]  addr_q, addr_d, addr_eff;
  logic [LenW-1:0]   seen_q, seen_d, seen_eff, seen_new;
  logic [CountW-1:0] count_q, count_d, count_eff, count_next;

  logic              accept, start, ignored, hit, report;
  logic [LenW-1:0]   len_eff;
  logic [LenW-1:0]   idx0;
  logic [7:0]        chain [MaxPat];
  logic [MaxPat-1:0] eq;

  logic                out_valid_q;
  bps_pkg::out_beat_t  out_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign start      = in_data_i.scan_start;

  assign len_eff = (length_q > LenW'(MaxPat)) ? LenW'(MaxPat) : length_q;

  // A scan-start beat sees the freshly cleared state.
  assign addr_eff  = start ? start_q : addr_q;
  assign seen_eff  = start ? '0 : seen_q;
  assign count_eff = start ? '0 : count_q;
  assign ignored   = (addr_eff >= end_q);
  assign seen_new  = (seen_eff < LenW'(MaxPat)) ? seen_eff + LenW'(1) : seen_eff;

  // The newest byte lines up with the last pattern byte.
  assign chain[0] = in_data_i.data_byte;
  assign idx0     = len_eff - LenW'(1);
  assign eq[0]    = (in_data_i.data_byte == bps_pkg::pattern_byte(pattern_q, idx0[2:0]));

  for (genvar k = 1; k < MaxPat; k++) begin : g_cell
    bps_pkg::cell_ctrl_t ctrl;
    logic [7:0]          cell_in;
    logic [LenW-1:0]     pidx;

    assign ctrl.shift  = accept && !ignored;
    assign ctrl.clear  = accept && start;
    assign ctrl.active = (LenW'(k) < len_eff);
    assign pidx        = len_eff - LenW'(1) - LenW'(k);
    // On a new scan the older cells fill with zeros behind the first byte.
    assign cell_in     = (k == 1 || !start) ? chain[k-1] : 8'h00;

    bps_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .byte_i     (cell_in),
      .pat_byte_i (bps_pkg::pattern_byte(pattern_q, pidx[2:0])),
      .byte_o     (chain[k]),
      .eq_o       (eq[k])
    );
  end

  assign hit        = (len_eff != '0) && (seen_new >= len_eff) && (&eq);
  assign report     = accept && !ignored && hit && (count_eff < limit_q);
  assign count_next = count_eff + CountW'(1);

  always_comb begin
    addr_d  = addr_q;
    seen_d  = seen_q;
    count_d = count_q;
    if (accept) begin
      addr_d  = ignored ? addr_eff : addr_eff + AddrW'(1);
      seen_d  = ignored ? seen_eff : seen_new;
      count_d = report ? count_next : count_eff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q      <= '0;
      seen_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      addr_q  <= addr_d;
      seen_q  <= seen_d;
      count_q <= count_d;
      if (in_ready_o) begin
        out_valid_q <= report;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && report) begin
      out_q.match_address <= addr_eff - AddrW'(len_eff - LenW'(1));
      out_q.match_number  <= count_next;
      out_q.limit_reached <= (count_next == limit_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== sv/bps_cell.sv =====
// ----------------------------------------------------------------------------
// Byte pattern search window cell
// Holds one earlier byte of the window, passes it on when the window shifts
// and compares it with the pattern byte that lines up with its position.
// ----------------------------------------------------------------------------
module bps_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bps_pkg::cell_ctrl_t ctrl_i,
  input  logic [7:0]          byte_i,
  input  logic [7:0]          pat_byte_i,
  output logic [7:0]          byte_o,
  output logic                eq_o
);

  logic [7:0] byte_q, byte_d;

  always_comb begin
    byte_d = byte_q;
    if (ctrl_i.shift) begin
      byte_d = byte_i;
    end else if (ctrl_i.clear) begin
      byte_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else begin
      byte_q <= byte_d;
    end
  end

  // A position beyond the pattern length always agrees.
  assign eq_o   = !ctrl_i.active || (byte_q == pat_byte_i);
  assign byte_o = byte_q;

endmodule

// ===== sv/bps_checker.sv =====
// ----------------------------------------------------------------------------
// Byte pattern search port checker
// Watches the core's ports and flags broken result beats and input stalls.
// ----------------------------------------------------------------------------
module bps_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         cfg_we_i,
  input logic [bps_pkg::CfgIdxW-1:0]  cfg_index_i,
  input logic [bps_pkg::CfgDataW-1:0] cfg_wdata_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input bps_pkg::out_beat_t           out_data_o
);

  logic [bps_pkg::CountW-1:0] limit_q;

  // Shadow of the match limit as seen on the write port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= bps_pkg::LimitReset;
    end else if (cfg_we_i && (cfg_index_i == bps_pkg::CfgLimit)) begin
      limit_q <= cfg_wdata_i[bps_pkg::CountW-1:0];
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat dropped or changed while stalled");

  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a stalled result");

  a_number_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.match_number != '0)
    else $error("match number of zero");

  a_number_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.match_number <= limit_q)
    else $error("match number beyond the limit");

  a_limit_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.limit_reached |-> out_data_o.match_number == limit_q)
    else $error("limit flag on a match below the limit");

endmodule

bind byte_pattern_search_core bps_checker u_bps_checker (.*);
